FILE: hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

   localparam int DEPTH     = 16;
   localparam int PRIO_BITS = 8;
   localparam int CHAR_BITS = 8;
   localparam int COUNT_W   = $clog2(DEPTH + 1);
   localparam int CAP_W     = 5;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [PRIO_BITS-1:0] prio;
      logic [CHAR_BITS-1:0] chr;
   } entry_type;

   // Broadcast to every cell of the chain
   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type new_entry;
   } cell_ctl_type;

endpackage

FILE: hw/rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry, shifts left or right with its neighbors.
module spq_cell import spq_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         occupied,
   input  logic         left_keep,
   input  entry_type    left_entry,
   input  entry_type    right_entry,
   output logic         keep,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // Stay in place when the new entry belongs behind this one
   assign keep = occupied && (entry_ff.prio <= ctl.new_entry.prio);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.enq) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (left_keep) begin
            entry_in = ctl.new_entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctl.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue built from a chain of shifting cells.
// A response enters the output register the cycle after its request is accepted.
// One transaction per cycle unless responses stall; every cell compares and shifts together.
// Reset (synchronous): queue empty, capacity 16, no response pending; entry data not cleared.
// A request is taken while the response register is empty or being drained.
module sorted_priority_queue import spq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [7:0]           req_entry_prio,
   input  logic [7:0]           req_entry_char,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_prio,
   output logic [7:0]           rsp_out_char,
   output logic [1:0]           rsp_status,
   output logic [4:0]           rsp_fill_count,
   // capacity register
   input  logic                 csr_wr_en,
   input  logic [CAP_W-1:0]     csr_wr_data
);

   localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

   logic [CAP_W-1:0]   capacity_ff;
   logic [CAP_W-1:0]   capacity_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [7:0]         rsp_prio_ff;
   logic [7:0]         rsp_prio_in;
   logic [7:0]         rsp_char_ff;
   logic [7:0]         rsp_char_in;
   status_type         rsp_status_ff;
   status_type         rsp_status_in;
   logic [COUNT_W-1:0] rsp_fill_ff;

   logic               accept;
   logic               is_deq;
   logic [COUNT_W-1:0] limit;
   logic               full;
   logic               empty;
   logic               do_enq;
   logic               do_deq;
   cell_ctl_type       ctl;

   entry_type          cell_entry [DEPTH];
   logic               cell_keep  [DEPTH];

   // Handshake: the response register frees up when it is empty or drained this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_deq    = (req_operation == OP_DEQUEUE);

   // Clamp capacity to the built depth; anything at or above the limit rejects enqueues
   assign limit = (COUNT_W'(capacity_ff) > DEPTH_C) ? DEPTH_C : COUNT_W'(capacity_ff);
   assign full  = (count_ff >= limit);
   assign empty = (count_ff == '0);

   assign do_enq = accept && !is_deq && !full;
   assign do_deq = accept && is_deq && !empty;

   assign ctl.enq            = do_enq;
   assign ctl.deq            = do_deq;
   assign ctl.new_entry.prio = req_entry_prio[PRIO_BITS-1:0];
   assign ctl.new_entry.chr  = req_entry_char;

   // Cell 0 is the head; an entry shifts right on enqueue and left on dequeue
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      occ;
      logic      lkeep;
      entry_type lentry;
      entry_type rentry;

      assign occ = (COUNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign lkeep  = 1'b1;
         assign lentry = ctl.new_entry;
      end else begin : g_body
         assign lkeep  = cell_keep[i-1];
         assign lentry = cell_entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign rentry = '0;
      end else begin : g_mid
         assign rentry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (occ),
         .left_keep   (lkeep),
         .left_entry  (lentry),
         .right_entry (rentry),
         .keep        (cell_keep[i]),
         .entry       (cell_entry[i])
      );
   end

   // Capacity register
   always_comb begin
      capacity_in = capacity_ff;
      if (csr_wr_en) begin
         capacity_in = csr_wr_data;
      end
   end

   // Occupancy count
   always_comb begin
      count_in = count_ff;
      if (do_enq) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_deq) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   // Response payload; data fields are zero except on a completed dequeue
   always_comb begin
      rsp_prio_in   = '0;
      rsp_char_in   = '0;
      rsp_status_in = ST_DONE;
      if (is_deq) begin
         if (empty) begin
            rsp_status_in = ST_EMPTY;
         end else begin
            rsp_prio_in = 8'(cell_entry[0].prio);
            rsp_char_in = cell_entry[0].chr;
         end
      end else if (full) begin
         rsp_status_in = ST_FULL;
      end
   end

   // Hold the response until taken; load a new one on every accepted request
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_W'(16);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_prio_ff   <= rsp_prio_in;
         rsp_char_ff   <= rsp_char_in;
         rsp_status_ff <= rsp_status_in;
         rsp_fill_ff   <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_prio   = rsp_prio_ff;
   assign rsp_out_char   = rsp_char_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fill_count = 5'(rsp_fill_ff);

   // Count never passes the built depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above depth");

   // A rejected enqueue leaves the count untouched
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      accept && !is_deq && full |=> $stable(count_ff))
      else $error("rejected enqueue changed count");

   // A completed dequeue drops the count by one
   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      do_deq |=> count_ff == $past(count_ff) - COUNT_W'(1))
      else $error("dequeue count mismatch");

   // The two front cells stay in priority order
   a_sorted_head: assert property (@(posedge clock) disable iff (reset)
      count_ff >= COUNT_W'(2) |-> cell_entry[0].prio <= cell_entry[1].prio)
      else $error("head cells out of order");

   // An empty rejection always reports an empty queue
   a_empty_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_EMPTY |-> rsp_fill_ff == '0)
      else $error("empty status with nonzero fill");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the sorted priority queue: directed and random traffic.
`timescale 1ns / 1ps

module testbench;
   import spq_pkg::*;

   // Generous bound on the whole run
   localparam int unsigned CYCLE_LIMIT = 200000;
   // Percent chance that a side idles on a given cycle
   localparam int unsigned IDLE_PCT = 6;

   // One response, as the queue should report it
   typedef struct {
      logic [7:0] prio;
      logic [7:0] chr;
      status_type status;
      logic [4:0] fill;
   } queue_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_operation = OP_ENQUEUE;
   logic [7:0] req_entry_prio = '0;
   logic [7:0] req_entry_char = '0;

   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_prio;
   logic [7:0] rsp_out_char;
   logic [1:0] rsp_status;
   logic [4:0] rsp_fill_count;

   logic             csr_wr_en = 1'b0;
   logic [CAP_W-1:0] csr_wr_data = '0;

   // Shadow of the queue: held entries in leaving order, plus the capacity register
   entry_type        held_entries[$];
   logic [CAP_W-1:0] capacity_setting = 5'd16;

   // Responses still owed by the queue, oldest first
   queue_result_type expected_results[$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   // Set to suppress idling on both channels
   bit          quiet_mode = 1'b0;

   sorted_priority_queue dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_entry_prio (req_entry_prio),
      .req_entry_char (req_entry_char),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_prio   (rsp_out_prio),
      .rsp_out_char   (rsp_out_char),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one operation to the shadow queue and return the response it must produce.
   // The store is a shifting chain in hardware, but only order matters from outside,
   // so a plain sorted list stands in for it.
   function automatic queue_result_type apply_queue_op(op_type op, logic [7:0] prio,
                                                       logic [7:0] chr);
      queue_result_type res;
      int unsigned      limit;
      int               pos;
      entry_type        item;
      res.prio   = '0;
      res.chr    = '0;
      res.status = ST_DONE;
      // A capacity above the built depth behaves as the full depth
      limit = (capacity_setting > DEPTH) ? DEPTH : capacity_setting;
      if (op == OP_ENQUEUE) begin
         if (held_entries.size() >= limit) begin
            res.status = ST_FULL;
         end else begin
            // Insert behind every entry of lower or equal priority: equal ones stay FIFO
            pos = 0;
            while (pos < held_entries.size() && held_entries[pos].prio <= prio)
               pos++;
            item.prio = prio;
            item.chr  = chr;
            held_entries.insert(pos, item);
         end
      end else begin
         if (held_entries.size() == 0) begin
            res.status = ST_EMPTY;
         end else begin
            item     = held_entries.pop_front();
            res.prio = item.prio;
            res.chr  = item.chr;
         end
      end
      res.fill = 5'(held_entries.size());
      return res;
   endfunction

   // Send one request transaction; on acceptance, record the response it owes.
   // Valid stays high across back-to-back transactions and drops only for an idle gap.
   task automatic send_request(op_type op, logic [7:0] prio, logic [7:0] chr);
      if (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_entry_prio <= prio;
      req_entry_char <= chr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(apply_queue_op(op, prio, chr));
   endtask

   // Hold off new requests until every owed response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Write the capacity register while the queue is idle
   task automatic write_capacity(logic [CAP_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      capacity_setting = value;
      csr_wr_en <= 1'b0;
   endtask

   // Dequeue from a queue that has never held anything
   task automatic test_dequeue_empty();
      send_request(OP_DEQUEUE, 8'hA5, 8'h5A);
   endtask

   // Mixed priorities with extremes and ties; ties must leave in arrival order
   task automatic test_priority_order();
      send_request(OP_ENQUEUE, 8'd200, 8'h61);
      send_request(OP_ENQUEUE, 8'd0,   8'hFF);
      send_request(OP_ENQUEUE, 8'd255, 8'h00);
      send_request(OP_ENQUEUE, 8'd200, 8'h62);
      send_request(OP_ENQUEUE, 8'd0,   8'h63);
      repeat (5) send_request(OP_DEQUEUE, 8'hFF, 8'hFF);
      // Empty again: this one is rejected
      send_request(OP_DEQUEUE, 8'h00, 8'h00);
   endtask

   // Capacity of one, capacity of zero, and capacity lowered below the fill level
   task automatic test_capacity_limits();
      write_capacity(5'd1);
      send_request(OP_ENQUEUE, 8'd50, 8'h11);
      send_request(OP_ENQUEUE, 8'd10, 8'h22);
      send_request(OP_DEQUEUE, 8'd0,  8'h00);
      write_capacity(5'd0);
      send_request(OP_ENQUEUE, 8'd1,  8'h33);
      write_capacity(5'd4);
      send_request(OP_ENQUEUE, 8'd9,  8'h44);
      send_request(OP_ENQUEUE, 8'd7,  8'h55);
      send_request(OP_ENQUEUE, 8'd8,  8'h66);
      // Three held, limit two: enqueues bounce until the count falls below two
      write_capacity(5'd2);
      send_request(OP_ENQUEUE, 8'd3,  8'h77);
      send_request(OP_DEQUEUE, 8'd0,  8'h00);
      send_request(OP_ENQUEUE, 8'd3,  8'h88);
      send_request(OP_DEQUEUE, 8'd0,  8'h00);
      send_request(OP_ENQUEUE, 8'd200, 8'h99);
   endtask

   // One random phase: enqueue-heavy first half to fill, dequeue-heavy second half to empty
   task automatic run_random_phase(logic [CAP_W-1:0] cap, int count, bit quiet,
                                   bit pause_midway);
      op_type     op;
      logic [7:0] prio;
      int         enq_pct;
      write_capacity(cap);
      quiet_mode = quiet;
      for (int i = 0; i < count; i++) begin
         if (pause_midway && i == count / 2)
            wait_drained();
         enq_pct = (i < count / 2) ? 75 : 25;
         op = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
         // Narrow priorities now and then so ties are common
         case ($urandom_range(3))
            0: prio = 8'($urandom_range(3));
            1: prio = $urandom_range(1) ? 8'hFF : 8'h00;
            default: prio = 8'($urandom_range(255));
         endcase
         send_request(op, prio, 8'($urandom_range(255)));
      end
      quiet_mode = 1'b0;
   endtask

   // Random traffic over several capacities, extremes included
   task automatic test_random_traffic();
      run_random_phase(5'd31, 100, 1'b0, 1'b0);
      run_random_phase(5'd16, 80,  1'b1, 1'b1);
      run_random_phase(5'd1,  40,  1'b0, 1'b0);
      run_random_phase(5'd5,  60,  1'b0, 1'b0);
      run_random_phase(5'd0,  20,  1'b0, 1'b0);
      run_random_phase(CAP_W'($urandom_range(31)), 50, 1'b0, 1'b0);
      run_random_phase(CAP_W'($urandom_range(31)), 50, 1'b0, 1'b0);
   endtask

   // Response side: random backpressure, none during quiet stretches
   always @(posedge clock) begin
      if (quiet_mode)
         rsp_ready <= 1'b1;
      else
         rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
   end

   task automatic compare_field(string name, logic [7:0] expected_v, logic [7:0] actual_v);
      if (actual_v !== expected_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, name, expected_v, actual_v);
         error_count++;
      end
   endtask

   // Check every response transaction against the oldest owed response
   always @(posedge clock) begin
      queue_result_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual prio %0d char %0d",
                     $time, rsp_out_prio, rsp_out_char);
            error_count++;
         end else begin
            exp = expected_results.pop_front();
            compare_field("out_prio",   exp.prio,       rsp_out_prio);
            compare_field("out_char",   exp.chr,        rsp_out_char);
            compare_field("status",     8'(exp.status), 8'(rsp_status));
            compare_field("fill_count", 8'(exp.fill),   8'(rsp_fill_count));
         end
      end
   end

   // Watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sorted_priority_queue test failed");
         $finish;
      end
   end

   initial begin
      // Hold reset, then release it once
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_dequeue_empty();
      test_priority_order();
      test_capacity_limits();
      test_random_traffic();

      // Let the last responses arrive, then leave time for stragglers
      wait_drained();
      repeat (5) @(posedge clock);
      if (error_count == 0)
         $display("sorted_priority_queue test passed");
      else
         $display("sorted_priority_queue test failed");
      $finish;
   end

endmodule
